// ----- rtl/rrht_pkg.sv -----
// rrht_pkg: shared widths, codes and controller/datapath interface types
// for the rectangle region hit tester. Depends on nothing.
package rrht_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int COUNT_W     = 5;
    localparam int REG_IDX_W   = 5;
    localparam int KIND_W      = 2;
    localparam int FIRST_W     = 4;
    localparam int MASK_W      = 16;

    // input tdata layout
    localparam int IN_IDX_LO = 0;
    localparam int IN_AX_LO  = IN_IDX_LO + REG_IDX_W;
    localparam int IN_AY_LO  = IN_AX_LO + COORD_BITS;
    localparam int IN_BX_LO  = IN_AY_LO + COORD_BITS;
    localparam int IN_BY_LO  = IN_BX_LO + COORD_BITS;
    localparam int IN_EN_LO  = IN_BY_LO + COORD_BITS;
    localparam int IN_PX_LO  = IN_EN_LO + 1;
    localparam int IN_PY_LO  = IN_PX_LO + COORD_BITS;
    localparam int IN_BITS   = IN_PY_LO + COORD_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_BITS    = 1 + FIRST_W + MASK_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic load_item;
        logic update;
        logic scan_step;
        logic load_out;
        logic cfg_write;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              scan_last;
        logic              out_free;
    } t_sts;

endpackage

// ----- rtl/rrht_datapath.sv -----
// rrht_datapath: region table, item registers, scan comparator and output register.
// Depends on rrht_pkg; driven by rrht_ctrl commands.
module rrht_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rrht_pkg::t_cmd                  i_cmd,
    output rrht_pkg::t_sts                  o_sts,
    input  logic [rrht_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [rrht_pkg::KIND_W-1:0]     i_s_tuser,
    input  logic [rrht_pkg::COUNT_W-1:0]    i_cfg_data,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rrht_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import rrht_pkg::*;

    // item registers
    logic [KIND_W-1:0]    r_kind;
    logic [REG_IDX_W-1:0] r_idx;
    t_coord               r_ax, r_ay, r_bx, r_by, r_px, r_py;
    logic                 r_en_flag;

    // region table
    t_coord               r_xl [MAX_REGIONS];
    t_coord               r_xh [MAX_REGIONS];
    t_coord               r_yl [MAX_REGIONS];
    t_coord               r_yh [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] r_written;
    logic [MAX_REGIONS-1:0] r_enabled;
    logic [COUNT_W-1:0]   r_count;

    // scan and result
    logic [IDX_W-1:0]     r_scan;
    logic                 r_found;
    logic [FIRST_W-1:0]   r_first;
    logic [MASK_W-1:0]    r_mask;
    logic                 r_err;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 idx_err;
    logic [IDX_W-1:0]     wr_idx;
    t_coord               rd_xl, rd_xh, rd_yl, rd_yh;
    logic                 hit;
    logic [COUNT_W-1:0]   scan_next;
    logic [COUNT_W-1:0]   cfg_sat;

    assign idx_err   = r_idx >= REG_IDX_W'(r_count);
    assign wr_idx    = r_idx[IDX_W-1:0];
    assign rd_xl     = r_written[r_scan] ? r_xl[r_scan] : '0;
    assign rd_xh     = r_written[r_scan] ? r_xh[r_scan] : '0;
    assign rd_yl     = r_written[r_scan] ? r_yl[r_scan] : '0;
    assign rd_yh     = r_written[r_scan] ? r_yh[r_scan] : '0;
    assign hit       = r_enabled[r_scan] && (r_px >= rd_xl) && (r_px <= rd_xh)
                       && (r_py >= rd_yl) && (r_py <= rd_yh);
    assign scan_next = COUNT_W'(r_scan) + COUNT_W'(1);
    assign cfg_sat   = (i_cfg_data > COUNT_W'(MAX_REGIONS)) ? COUNT_W'(MAX_REGIONS)
                                                            : i_cfg_data;

    assign o_sts.kind       = r_kind;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_last  = (scan_next == r_count);
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // item capture, scan and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind    <= i_s_tuser;
            r_idx     <= i_s_tdata[IN_IDX_LO +: REG_IDX_W];
            r_ax      <= i_s_tdata[IN_AX_LO +: COORD_BITS];
            r_ay      <= i_s_tdata[IN_AY_LO +: COORD_BITS];
            r_bx      <= i_s_tdata[IN_BX_LO +: COORD_BITS];
            r_by      <= i_s_tdata[IN_BY_LO +: COORD_BITS];
            r_en_flag <= i_s_tdata[IN_EN_LO];
            r_px      <= i_s_tdata[IN_PX_LO +: COORD_BITS];
            r_py      <= i_s_tdata[IN_PY_LO +: COORD_BITS];
            r_scan    <= '0;
            r_found   <= 1'b0;
            r_first   <= '0;
            r_mask    <= '0;
            r_err     <= 1'b0;
        end else if (i_cmd.update) begin
            r_err <= idx_err;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + IDX_W'(1);
            if (hit) begin
                r_mask <= r_mask | (MASK_W'(1) << r_scan);
                if (!r_found) begin
                    r_found <= 1'b1;
                    r_first <= FIRST_W'(r_scan);
                end
            end
        end
    end

    // box storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !idx_err && r_kind == KIND_WRITE) begin
            r_xl[wr_idx] <= (r_ax < r_bx) ? r_ax : r_bx;
            r_xh[wr_idx] <= (r_ax > r_bx) ? r_ax : r_bx;
            r_yl[wr_idx] <= (r_ay < r_by) ? r_ay : r_by;
            r_yh[wr_idx] <= (r_ay > r_by) ? r_ay : r_by;
        end
    end

    // enables, written marks, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_enabled <= '0;
            r_count   <= '0;
        end else if (i_cmd.cfg_write) begin
            r_enabled <= '0;
            r_count   <= cfg_sat;
        end else if (i_cmd.update && !idx_err) begin
            r_enabled[wr_idx] <= r_en_flag;
            if (r_kind == KIND_WRITE) begin
                r_written[wr_idx] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= OUT_TDATA_W'({r_err, r_mask, r_first, r_found});
        end
    end

endmodule

// ----- rtl/rrht_ctrl.sv -----
// rrht_ctrl: sequencing state machine for the hit tester.
// Depends on rrht_pkg; commands rrht_datapath.
module rrht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  rrht_pkg::t_sts i_sts,
    output rrht_pkg::t_cmd o_cmd
);
    import rrht_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.cfg_write = i_cfg_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.kind == KIND_WRITE || i_sts.kind == KIND_ENABLE) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_DONE;
                end else if (i_sts.kind == KIND_QUERY && !i_sts.count_zero) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/rect_region_hit_test.sv -----
// rect_region_hit_test: top level joining rrht_ctrl and rrht_datapath.
// Depends on rrht_pkg, rrht_ctrl and rrht_datapath.
//
//  channel  direction  handshake                     payload
//  s_axis   in         i_s_axis_tvalid/o_s_axis_tready  tdata 104b, tuser kind
//  m_axis   out        o_m_axis_tvalid/i_m_axis_tready  tdata 24b
//  cfg      in         i_cfg_valid/o_cfg_ready          region_count 5b
//
// write, enable and unused-kind items pass the exec and done states; a query
// with nonzero region_count scans between, one stored region compared per cycle.
// one item is in work at a time; the output register holds a result while
// the next item is accepted. reset is synchronous, active low, and clears the
// enables, the count and the written marks of the region table.
module rect_region_hit_test (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // region_index, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
    // enable_flag, point_x, point_y, zero pad
    input  logic [rrht_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic [rrht_pkg::KIND_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // hit_found, first_hit, hit_mask, index_error, zero pad
    output logic [rrht_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rrht_pkg::COUNT_W-1:0]     i_cfg_data
);
    import rrht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rrht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rrht_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

// ----- tb/rrht_checker.sv -----
// rrht_checker: watches the item, result and region_count channels of the
// rectangle region hit tester, predicts every result and compares it.
// Depends on rrht_pkg only.
module rrht_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [rrht_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic [rrht_pkg::KIND_W-1:0]      i_in_kind,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [rrht_pkg::OUT_TDATA_W-1:0] i_out_data,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [rrht_pkg::COUNT_W-1:0]     i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding,
    output int                               o_hits
);
    import rrht_pkg::*;

    typedef struct packed {
        logic               hit_found;
        logic [FIRST_W-1:0] first_hit;
        logic [MASK_W-1:0]  hit_mask;
        logic               index_error;
    } t_hit_result;

    t_coord             x_lo [MAX_REGIONS];
    t_coord             x_hi [MAX_REGIONS];
    t_coord             y_lo [MAX_REGIONS];
    t_coord             y_hi [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] enabled;
    logic [COUNT_W-1:0] regions_in_use;
    t_hit_result        pending_results [$];

    assign o_outstanding = pending_results.size();

    function automatic t_hit_result apply_item(logic [KIND_W-1:0] kind,
                                               logic [IN_TDATA_W-1:0] d);
        t_hit_result        r;
        logic [REG_IDX_W-1:0] idx;
        logic [IDX_W-1:0]   slot;
        t_coord             ax, ay, bx, by, px, py;
        logic               en;
        r    = '0;
        idx  = d[IN_IDX_LO +: REG_IDX_W];
        slot = idx[IDX_W-1:0];
        ax   = d[IN_AX_LO +: COORD_BITS];
        ay   = d[IN_AY_LO +: COORD_BITS];
        bx   = d[IN_BX_LO +: COORD_BITS];
        by   = d[IN_BY_LO +: COORD_BITS];
        en   = d[IN_EN_LO];
        px   = d[IN_PX_LO +: COORD_BITS];
        py   = d[IN_PY_LO +: COORD_BITS];
        if (kind == KIND_WRITE || kind == KIND_ENABLE) begin
            if (idx >= regions_in_use) begin
                r.index_error = 1'b1;
            end else begin
                if (kind == KIND_WRITE) begin
                    x_lo[slot] = (ax < bx) ? ax : bx;
                    x_hi[slot] = (ax < bx) ? bx : ax;
                    y_lo[slot] = (ay < by) ? ay : by;
                    y_hi[slot] = (ay < by) ? by : ay;
                end
                enabled[slot] = en;
            end
        end else if (kind == KIND_QUERY) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                if (i < regions_in_use && enabled[i] &&
                    px >= x_lo[i] && px <= x_hi[i] &&
                    py >= y_lo[i] && py <= y_hi[i]) begin
                    if (!r.hit_found) begin
                        r.hit_found = 1'b1;
                        r.first_hit = i[FIRST_W-1:0];
                    end
                    r.hit_mask[i] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hit_result want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                x_lo[i] = '0;
                x_hi[i] = '0;
                y_lo[i] = '0;
                y_hi[i] = '0;
            end
            enabled        = '0;
            regions_in_use = '0;
            o_mismatches   = 0;
            o_hits         = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                regions_in_use = (i_cfg_data > MAX_REGIONS) ? COUNT_W'(MAX_REGIONS)
                                                           : i_cfg_data;
                enabled = '0;
            end
            if (i_out_valid && i_out_ready) begin
                got.hit_found   = i_out_data[0];
                got.first_hit   = i_out_data[1 +: FIRST_W];
                got.hit_mask    = i_out_data[1 + FIRST_W +: MASK_W];
                got.index_error = i_out_data[1 + FIRST_W + MASK_W];
                if (pending_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected result %h with nothing pending", i_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit_found)
                        o_hits++;
                    if (got.hit_found != want.hit_found || got.first_hit != want.first_hit ||
                        got.hit_mask != want.hit_mask ||
                        got.index_error != want.index_error) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch: want %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                     want.hit_found, want.first_hit, want.hit_mask,
                                     want.index_error, got.hit_found, got.first_hit,
                                     got.hit_mask, got.index_error);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_item(i_in_kind, i_in_data));
        end
    end

endmodule

// ----- tb/rect_region_hit_test_test.sv -----
// rect_region_hit_test_test: stimulus and verdict for the rectangle region
// hit tester; checking is done by rrht_checker beside the block.
// Depends on rrht_pkg, rect_region_hit_test and rrht_checker.
module rect_region_hit_test_test;
    import rrht_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 24;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [KIND_W-1:0]      s_kind = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COUNT_W-1:0]     cfg_data = '0;
    logic                   calm = 1'b0;

    int mismatches, outstanding, hits;
    int idle_cycles = 0;
    int n_write = 0, n_enable = 0, n_query = 0, n_unused = 0, n_settings = 0;
    int live_count = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rect_region_hit_test dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    rrht_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_valid),
        .i_in_ready    (s_ready),
        .i_in_data     (s_data),
        .i_in_kind     (s_kind),
        .i_out_valid   (m_valid),
        .i_out_ready   (m_ready),
        .i_out_data    (m_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_hits        (hits)
    );

    // result side back-pressure
    always @(negedge clk) begin
        m_ready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [REG_IDX_W-1:0] idx,
                             input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] bx, input logic [15:0] by,
                             input logic en, input logic [15:0] px,
                             input logic [15:0] py);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_IDX_LO +: REG_IDX_W] = idx;
        word[IN_AX_LO +: COORD_BITS] = ax;
        word[IN_AY_LO +: COORD_BITS] = ay;
        word[IN_BX_LO +: COORD_BITS] = bx;
        word[IN_BY_LO +: COORD_BITS] = by;
        word[IN_EN_LO]               = en;
        word[IN_PX_LO +: COORD_BITS] = px;
        word[IN_PY_LO +: COORD_BITS] = py;
        case (kind)
            KIND_WRITE:  n_write++;
            KIND_ENABLE: n_enable++;
            KIND_QUERY:  n_query++;
            default:     n_unused++;
        endcase
        @(negedge clk);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_kind  <= kind;
        do @(posedge clk); while (!s_ready);
    endtask

    task automatic put_box(input logic [REG_IDX_W-1:0] idx, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] bx,
                           input logic [15:0] by, input logic en);
        send_item(KIND_WRITE, idx, ax, ay, bx, by, en, 16'($urandom), 16'($urandom));
    endtask

    task automatic set_enable(input logic [REG_IDX_W-1:0] idx, input logic en);
        send_item(KIND_ENABLE, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), en, 16'($urandom), 16'($urandom));
    endtask

    task automatic query_at(input logic [15:0] px, input logic [15:0] py);
        send_item(KIND_QUERY, REG_IDX_W'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom), px, py);
    endtask

    // hold the item side quiet until every result is back
    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_region_count(input logic [COUNT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        live_count = (v > MAX_REGIONS) ? MAX_REGIONS : v;
        n_settings++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom_range(128)) - 16'd64;
        endcase
    endfunction

    task automatic random_item();
        logic [REG_IDX_W-1:0] idx;
        int pick;
        if (live_count == 0 || $urandom_range(99) < 8)
            idx = REG_IDX_W'($urandom_range(31));
        else
            idx = REG_IDX_W'($urandom_range(live_count - 1));
        pick = $urandom_range(99);
        if (pick < 35)
            put_box(idx, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(3) != 0);
        else if (pick < 47)
            set_enable(idx, $urandom_range(3) != 0);
        else if (pick < 97)
            query_at(rand_coord(), rand_coord());
        else
            send_item(KIND_UNUSED, REG_IDX_W'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
    endtask

    initial begin
        logic [COUNT_W-1:0] phase_counts [8];
        phase_counts = '{5'd16, 5'd3, 5'd0, 5'd1, 5'd31, 5'd9, 5'd20, 5'd16};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no region in use yet
        put_box(5'd0, 16'd16, 16'd16, -16'sd16, -16'sd16, 1'b1);
        set_enable(5'd0, 1'b1);
        query_at(16'd0, 16'd0);
        send_item(KIND_UNUSED, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                  16'hFFFF, 16'hFFFF);

        // count above the table size saturates
        write_region_count(5'd31);
        set_enable(5'd3, 1'b1);
        query_at(16'd0, 16'd0);
        put_box(5'd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1);
        put_box(5'd15, -16'sd16, 16'd16, 16'd16, -16'sd16, 1'b1);
        put_box(5'd16, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        put_box(5'd31, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        query_at(16'sh8000, 16'sh8000);
        query_at(16'sh7FFF, 16'sh7FFF);
        query_at(16'd16, -16'sd16);
        query_at(16'd17, 16'd0);
        set_enable(5'd0, 1'b0);
        query_at(16'd0, 16'd0);
        put_box(5'd5, 16'd100, -16'sd100, 16'd100, -16'sd100, 1'b1);
        query_at(16'd100, -16'sd100);
        query_at(16'd101, -16'sd100);
        send_item(KIND_UNUSED, 5'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                  16'h0000, 16'h0000);

        // a new count clears the enables but keeps the boxes
        write_region_count(5'd1);
        query_at(16'd0, 16'd0);
        set_enable(5'd1, 1'b1);
        set_enable(5'd0, 1'b1);
        query_at(16'sh8000, 16'sh7FFF);

        for (int p = 0; p < 9; p++) begin
            write_region_count(p < 8 ? phase_counts[p] : COUNT_W'($urandom_range(2, 15)));
            calm = (p == 1);
            repeat (phase_counts[p % 8] == 0 ? 40 : 95) random_item();
        end
        calm = 1'b0;

        settle();
        $display("covered %0d writes, %0d enable changes, %0d queries, %0d unused-kind items",
                 n_write, n_enable, n_query, n_unused);
        $display("over %0d region_count settings; %0d queries found a region",
                 n_settings, hits);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
